@@ sv/stk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_pkg
// types, token kind codes and character constants shared by the tokenizer
// ----------------------------------------------------------------------------
package stk_pkg;

  // token kinds
  localparam logic [4:0] KIND_ID     = 5'd0;
  localparam logic [4:0] KIND_NUM    = 5'd1;
  localparam logic [4:0] KIND_STR    = 5'd2;
  localparam logic [4:0] KIND_LBRACE = 5'd3;
  localparam logic [4:0] KIND_RBRACE = 5'd4;
  localparam logic [4:0] KIND_LBRACK = 5'd5;
  localparam logic [4:0] KIND_RBRACK = 5'd6;
  localparam logic [4:0] KIND_LPAREN = 5'd7;
  localparam logic [4:0] KIND_RPAREN = 5'd8;
  localparam logic [4:0] KIND_ASSIGN = 5'd9;
  localparam logic [4:0] KIND_SEMI   = 5'd10;
  localparam logic [4:0] KIND_COMMA  = 5'd11;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd13;
  localparam logic [4:0] KIND_STAR   = 5'd14;
  localparam logic [4:0] KIND_SLASH  = 5'd15;
  localparam logic [4:0] KIND_PCT    = 5'd16;
  localparam logic [4:0] KIND_DOT    = 5'd17;
  localparam logic [4:0] KIND_EOF    = 5'd18;
  localparam logic [4:0] KIND_ERR    = 5'd19;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } src_item_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    logic       run_last;
  } tok_item_t;

  // all results caused by one source byte
  typedef struct packed {
    logic [1:0]           count;
    tok_item_t [2:0]      item;
  } tok_bundle_t;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_ID   = 5'b00010,
    MODE_NUM  = 5'b00100,
    MODE_STR  = 5'b01000,
    MODE_HALT = 5'b10000
  } lex_mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // punctuator kind, KIND_ERR when the byte is no punctuator
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_ERR;
    case (c)
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3D:   k = KIND_ASSIGN;
      8'h3B:   k = KIND_SEMI;
      8'h2C:   k = KIND_COMMA;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h25:   k = KIND_PCT;
      8'h2E:   k = KIND_DOT;
      default: k = KIND_ERR;
    endcase
    return k;
  endfunction

  function automatic tok_item_t mk_item(input logic [4:0] kind, input logic [7:0] b,
                                        input logic hb, input logic st, input logic en);
    tok_item_t t;
    t.token_kind  = kind;
    t.value_byte  = b;
    t.has_byte    = hb;
    t.token_start = st;
    t.token_end   = en;
    t.run_last    = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/source_tokenizer_stream_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_tokenizer_stream_unit
// streaming lexer: source bytes in, token-marked characters out
// ----------------------------------------------------------------------------
// each result is stored in the bundle queue as its byte is taken and is shown once it reaches the head
// throughput: one byte per cycle while full is low; a byte with k results needs k pop
//   transfers on the output side, absorbed by a DEPTH-entry bundle queue before full rises
// full follows the queue fill; halted bytes are still taken but give nothing
// reset (rst, synchronous): lexer idle, queue and output walk cleared
module source_tokenizer_stream_unit import stk_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  // source side
  input  wire logic      push,
  output logic           full,
  input  wire src_item_t src_item,
  // result side
  output logic           empty,
  input  wire logic      pop,
  output tok_item_t      tok_item
);

  logic        accept;
  tok_bundle_t fr_bundle;
  logic        fr_valid;
  tok_bundle_t head;
  logic        q_empty;
  logic        q_rd;

  // byte transfer in whenever the queue has room
  assign accept = push && !full;

  // front: mode register and byte classification
  stk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .src_item     (src_item),
    .bundle       (fr_bundle),
    .bundle_valid (fr_valid)
  );

  // bundles with no result never enter the queue
  stk_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_valid),
    .wr_data (fr_bundle),
    .rd_en   (q_rd),
    .rd_data (head),
    .q_empty (q_empty),
    .q_full  (full)
  );

  // back: one result per pop transfer, head released after its last one
  stk_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .q_rd     (q_rd),
    .tok_item (tok_item),
    .empty    (empty)
  );

endmodule

`default_nettype wire

@@ sv/stk_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_front
// holds the lexer mode and classifies each source byte into a result bundle
// ----------------------------------------------------------------------------
module stk_front import stk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire src_item_t   src_item,
  output tok_bundle_t      bundle,
  output logic             bundle_valid
);

  lex_mode_t mode;
  lex_mode_t mode_next;

  always_comb begin
    logic [7:0]      c;
    logic            eot;
    logic [1:0]      n;
    logic            go_idle;
    logic            cont;
    logic [4:0]      run_kind;
    logic [4:0]      pk;
    tok_item_t [2:0] items;

    c         = src_item.char_byte;
    eot       = src_item.end_of_text;
    n         = 2'd0;
    go_idle   = 1'b0;
    cont      = 1'b0;
    items     = '0;
    mode_next = mode;
    run_kind  = (mode == MODE_ID) ? KIND_ID : KIND_NUM;
    pk        = punct_kind(c);

    unique case (mode) inside
      MODE_HALT: begin
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          items[n] = mk_item(KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1); n = n + 2'd1;
          mode_next = MODE_IDLE;
          if (eot) begin
            items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
          end
        end else if (c == CH_NUL) begin
          items[n] = mk_item(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
          mode_next = MODE_HALT;
        end else begin
          items[n] = mk_item(KIND_STR, c, 1'b1, 1'b0, 1'b0); n = n + 2'd1;
          if (eot) begin
            items[n] = mk_item(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
            mode_next = MODE_HALT;
          end
        end
      end
      MODE_ID, MODE_NUM: begin
        cont = (mode == MODE_ID) ? (is_letter(c) || is_digit(c) || (c == CH_UNDER))
                                 : is_digit(c);
        if (cont) begin
          items[n] = mk_item(run_kind, c, 1'b1, 1'b0, eot); n = n + 2'd1;
          if (eot) begin
            items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
            mode_next = MODE_IDLE;
          end
        end else begin
          // close the run, then treat the byte as in idle
          items[n] = mk_item(run_kind, 8'h00, 1'b0, 1'b0, 1'b1); n = n + 2'd1;
          mode_next = MODE_IDLE;
          go_idle   = 1'b1;
        end
      end
      MODE_IDLE: begin
        go_idle = 1'b1;
      end
      default: begin
      end
    endcase

    if (go_idle) begin
      if (c == CH_NUL) begin
        items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
      end else if ((c == CH_SPACE) || (c == CH_LF)) begin
        if (eot) begin
          items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
        end
      end else if (is_digit(c) || is_letter(c)) begin
        items[n] = mk_item(is_digit(c) ? KIND_NUM : KIND_ID, c, 1'b1, 1'b1, eot);
        n = n + 2'd1;
        if (eot) begin
          items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
        end else begin
          mode_next = is_digit(c) ? MODE_NUM : MODE_ID;
        end
      end else if (c == CH_QUOTE) begin
        items[n] = mk_item(KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0); n = n + 2'd1;
        if (eot) begin
          items[n] = mk_item(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
          mode_next = MODE_HALT;
        end else begin
          mode_next = MODE_STR;
        end
      end else if (pk != KIND_ERR) begin
        items[n] = mk_item(pk, c, 1'b1, 1'b1, 1'b1); n = n + 2'd1;
        if (eot) begin
          items[n] = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
        end
      end else begin
        items[n] = mk_item(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0); n = n + 2'd1;
        mode_next = MODE_HALT;
      end
    end

    // mark the last result of this byte
    if (n != 2'd0) begin
      items[n - 2'd1].run_last = 1'b1;
    end

    bundle.count = n;
    bundle.item  = items;
    bundle_valid = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/stk_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_queue
// short queue of result bundles between the classifier and the output side
// ----------------------------------------------------------------------------
module stk_queue import stk_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire tok_bundle_t wr_data,
  input  wire logic        rd_en,
  output tok_bundle_t      rd_data,
  output logic             q_empty,
  output logic             q_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tok_bundle_t       store [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign q_empty = (count == '0);
  assign q_full  = (count == (AW + 1)'(DEPTH));
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/stk_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_back
// walks the head bundle one result at a time and releases it when done
// ----------------------------------------------------------------------------
module stk_back import stk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tok_bundle_t head,
  input  wire logic        q_empty,
  input  wire logic        pop,
  output logic             q_rd,
  output tok_item_t        tok_item,
  output logic             empty
);

  logic [1:0] idx;
  logic       last;

  assign last     = (idx == (head.count - 2'd1));
  assign empty    = q_empty;
  assign tok_item = head.item[idx];
  assign q_rd     = pop && !q_empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && !q_empty) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_source_tokenizer_stream_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_tokenizer_stream_unit
// self-checking bench for the streaming lexer: a directed text, a long run of
// random but mostly well-formed token text under random idling and a forced
// back-pressure stretch, then one randomly chosen halting error case
// ----------------------------------------------------------------------------
module tb_source_tokenizer_stream_unit;
  import stk_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_BYTES = 250;
  localparam int HOLD_CYCLES  = 48;   // long receiver hold-off, well past the queue depth
  localparam int DRAIN_CYCLES = 20;   // quiet cycles at the end to catch stray results
  localparam int MAX_REPORTS  = 10;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  src_item_t src_item;
  logic      empty;
  logic      pop;
  tok_item_t tok_item;

  // lexer state as the bench sees it, and the token items still owed by the block
  lex_mode_t lex_state;
  tok_item_t tok_expected_q[$];
  tok_item_t step_buf[3];
  int        step_n;

  int    src_sent;
  int    tok_checked;
  int    fail_count;
  int    full_stalls;
  bit    tx_idle_on;
  bit    rx_idle_on;
  int    rx_hold_req;
  string halt_case;

  source_tokenizer_stream_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .src_item (src_item),
    .empty    (empty),
    .pop      (pop),
    .tok_item (tok_item)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout: %0d token items still expected", tok_expected_q.size());
    $display("tb_source_tokenizer_stream_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // character classes and the punctuator table
  // ---------------------------------------------------------------------------
  function automatic bit is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [4:0] punct_of(input logic [7:0] c, output bit found);
    logic [4:0] k;
    found = 1'b1;
    k = KIND_ERR;
    case (c)
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "=":     k = KIND_ASSIGN;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PCT;
      ".":     k = KIND_DOT;
      default: found = 1'b0;
    endcase
    return k;
  endfunction

  // punctuator by table position, in token kind order
  function automatic logic [7:0] punct_char(input int i);
    case (i)
      0:       return "{";
      1:       return "}";
      2:       return "[";
      3:       return "]";
      4:       return "(";
      5:       return ")";
      6:       return "=";
      7:       return ";";
      8:       return ",";
      9:       return "+";
      10:      return "-";
      11:      return "*";
      12:      return "/";
      13:      return "%";
      default: return ".";
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // token prediction: one accepted source byte gives up to three items
  // ---------------------------------------------------------------------------
  function automatic void add_token(input logic [4:0] kind, input logic [7:0] b,
                                    input logic hb, input logic st, input logic en);
    step_buf[step_n].token_kind  = kind;
    step_buf[step_n].value_byte  = b;
    step_buf[step_n].has_byte    = hb;
    step_buf[step_n].token_start = st;
    step_buf[step_n].token_end   = en;
    step_buf[step_n].run_last    = 1'b0;
    step_n++;
  endfunction

  function automatic void predict_tokens(input src_item_t s);
    logic [7:0] c;
    logic       eot;
    logic [4:0] kind;
    logic [4:0] pk;
    bit         cont;
    bit         found;
    bit         handled;
    c = s.char_byte;
    eot = s.end_of_text;
    handled = 1'b0;
    step_n = 0;
    // halted: byte is taken but nothing comes out
    if (lex_state == MODE_HALT) return;

    if (lex_state == MODE_STR) begin
      handled = 1'b1;
      if (c == CH_QUOTE) begin
        add_token(KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1);
        lex_state = MODE_IDLE;
        if (eot) add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
      end else if (c == CH_NUL) begin
        add_token(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
        lex_state = MODE_HALT;
      end else begin
        add_token(KIND_STR, c, 1'b1, 1'b0, 1'b0);
        if (eot) begin
          add_token(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
          lex_state = MODE_HALT;
        end
      end
    end else if (lex_state == MODE_ID || lex_state == MODE_NUM) begin
      kind = (lex_state == MODE_ID) ? KIND_ID : KIND_NUM;
      cont = (lex_state == MODE_ID) ? (is_alpha(c) || is_dec(c) || c == CH_UNDER) : is_dec(c);
      if (cont) begin
        handled = 1'b1;
        add_token(kind, c, 1'b1, 1'b0, eot);
        if (eot) begin
          add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
          lex_state = MODE_IDLE;
        end
      end else begin
        // run closed by a separate end marker, byte then handled from idle
        add_token(kind, 8'h00, 1'b0, 1'b0, 1'b1);
        lex_state = MODE_IDLE;
      end
    end

    if (!handled) begin
      pk = punct_of(c, found);
      if (c == CH_NUL) begin
        add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
      end else if (c == CH_SPACE || c == CH_LF) begin
        if (eot) add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
      end else if (is_dec(c) || is_alpha(c)) begin
        kind = is_dec(c) ? KIND_NUM : KIND_ID;
        add_token(kind, c, 1'b1, 1'b1, eot);
        if (eot) add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
        else lex_state = is_dec(c) ? MODE_NUM : MODE_ID;
      end else if (c == CH_QUOTE) begin
        add_token(KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0);
        if (eot) begin
          add_token(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
          lex_state = MODE_HALT;
        end else begin
          lex_state = MODE_STR;
        end
      end else if (found) begin
        add_token(pk, c, 1'b1, 1'b1, 1'b1);
        if (eot) add_token(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0);
      end else begin
        add_token(KIND_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
        lex_state = MODE_HALT;
      end
    end

    if (step_n > 0) step_buf[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) tok_expected_q.push_back(step_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result check, field by field against the oldest owed item
  // ---------------------------------------------------------------------------
  function automatic void check_token(input tok_item_t got);
    tok_item_t want;
    bit        bad;
    tok_checked++;
    if (tok_expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected token item kind %0d byte %02h", $realtime,
                 got.token_kind, got.value_byte);
      return;
    end
    want = tok_expected_q.pop_front();
    bad = (got.token_kind  !== want.token_kind)  || (got.value_byte !== want.value_byte) ||
          (got.has_byte    !== want.has_byte)    || (got.token_start !== want.token_start) ||
          (got.token_end   !== want.token_end)   || (got.run_last   !== want.run_last);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display({"%0t: mismatch exp kind %0d byte %02h hb %0b st %0b en %0b last %0b",
                  " / got kind %0d byte %02h hb %0b st %0b en %0b last %0b"},
                 $realtime, want.token_kind, want.value_byte, want.has_byte,
                 want.token_start, want.token_end, want.run_last,
                 got.token_kind, got.value_byte, got.has_byte,
                 got.token_start, got.token_end, got.run_last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // source side: entered and left at a falling edge; push stays high on return
  // so that back-to-back transfers need no extra edge
  // ---------------------------------------------------------------------------
  task automatic send_src(input logic [7:0] b, input logic eot);
    int        gap;
    src_item_t s;
    gap = tx_idle_on ? $urandom_range(5, 0) : 0;
    s.char_byte = b;
    s.end_of_text = eot;
    repeat (gap) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    src_item <= s;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    // transfer taken at this edge
    predict_tokens(s);
    src_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string t, input logic eot_last);
    for (int i = 0; i < t.len(); i++)
      send_src(t[i], eot_last && (i == t.len() - 1));
  endtask

  // sender rests until every owed item is back
  task automatic wait_drained();
    push <= 1'b0;
    while (tok_expected_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random waits per transfer, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end
      gap = rx_idle_on ? $urandom_range(5, 0) : 0;
      repeat (gap) begin
        pop <= 1'b0;
        @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_token(tok_item);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every token kind but the error kind, run closing by each route, end of text in its forms
  task automatic test_directed_text();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // identifier with upper, lower, underscore and digit, then a newline
    send_text("Zz_9\n", 1'b0);
    // number then letter: number closes, identifier starts, closed by a brace
    send_text("09a", 1'b0);
    for (int i = 0; i < 15; i++) send_src(punct_char(i), 1'b0);
    // string holding a space, closing quote ends the text
    send_text("\" \"", 1'b1);
    // number start carrying end of text, then a space carrying it
    send_text("7", 1'b1);
    send_text(" ", 1'b1);
    // open identifier closed by a NUL end of text, then a fresh text
    send_text("b", 1'b0);
    send_src(CH_NUL, 1'b0);
    wait_drained();
  endtask

  // mostly well-formed token text with random content; runs may merge
  task automatic test_random_text();
    int         first;
    int         sel;
    int         len;
    int         r;
    logic [7:0] b;
    first = src_sent;
    while (src_sent - first < RANDOM_BYTES) begin
      if ($urandom_range(9, 0) == 0) tx_idle_on = ~tx_idle_on;
      if ($urandom_range(9, 0) == 0) rx_idle_on = ~rx_idle_on;
      sel = $urandom_range(99, 0);
      if (sel < 22) begin
        // identifier
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          r = (i == 0) ? $urandom_range(51, 0) : $urandom_range(62, 0);
          if (r < 26) b = 8'("a" + r);
          else if (r < 52) b = 8'("A" + (r - 26));
          else if (r < 62) b = 8'("0" + (r - 52));
          else b = CH_UNDER;
          send_src(b, (i == len - 1) && ($urandom_range(7, 0) == 0));
        end
        if ($urandom_range(1, 0) == 0) send_src(CH_SPACE, 1'b0);
      end else if (sel < 40) begin
        // number
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++)
          send_src(8'("0" + $urandom_range(9, 0)),
                   (i == len - 1) && ($urandom_range(7, 0) == 0));
        if ($urandom_range(1, 0) == 0) send_src(CH_LF, 1'b0);
      end else if (sel < 55) begin
        // string of any byte but NUL and quote, high bytes included
        send_src(CH_QUOTE, 1'b0);
        len = $urandom_range(4, 0);
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom_range(255, 1));
          if (b == CH_QUOTE) b = 8'hFF;
          send_src(b, 1'b0);
        end
        send_src(CH_QUOTE, $urandom_range(7, 0) == 0);
      end else if (sel < 75) begin
        send_src(punct_char($urandom_range(14, 0)), $urandom_range(9, 0) == 0);
      end else if (sel < 92) begin
        send_src($urandom_range(1, 0) ? CH_SPACE : CH_LF, $urandom_range(7, 0) == 0);
      end else begin
        send_src(CH_NUL, 1'($urandom_range(1, 0)));
      end
      // now and then the sender rests until the block has caught up
      if ($urandom_range(39, 0) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps pushing, so full must rise
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_src("q", 1'b0);
      else send_src(punct_char($urandom_range(14, 0)), 1'b0);
    end
    send_src(CH_NUL, 1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  // one halting error per run, chosen at random, then bytes that must be ignored
  task automatic test_halt_on_error();
    int sel;
    send_src(CH_LF, 1'b0);
    sel = $urandom_range(5, 0);
    case (sel)
      0: begin
        halt_case = "identifier closed by a byte above 127";
        send_text("x", 1'b0);
        send_src(8'hFF, 1'b0);
      end
      1: begin
        halt_case = "number closed by a tab";
        send_text("42", 1'b0);
        send_src(8'h09, 1'b0);
      end
      2: begin
        halt_case = "underscore at token start";
        send_src(CH_UNDER, 1'b0);
      end
      3: begin
        halt_case = "NUL inside a string";
        send_text("\"a", 1'b0);
        send_src(CH_NUL, 1'b0);
      end
      4: begin
        halt_case = "end of text on a string byte";
        send_text("\"b", 1'b1);
      end
      default: begin
        halt_case = "end of text on an opening quote";
        send_src(CH_QUOTE, 1'b1);
      end
    endcase
    for (int i = 0; i < 10; i++)
      send_src(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
    push <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    push = 1'b0;
    src_item = '0;
    lex_state = MODE_IDLE;
    step_n = 0;
    src_sent = 0;
    tok_checked = 0;
    fail_count = 0;
    full_stalls = 0;
    rx_hold_req = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    halt_case = "none";
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_text();
    test_random_text();
    test_backpressure();
    test_halt_on_error();

    while (tok_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run: %0d source bytes in, %0d token items checked, %0d cycles with full high",
             src_sent, tok_checked, full_stalls);
    $display("halting case exercised: %s", halt_case);
    if (fail_count == 0 && tok_expected_q.size() == 0) begin
      $display("tb_source_tokenizer_stream_unit: PASS");
    end else begin
      $display("%0d failures, %0d items left over", fail_count, tok_expected_q.size());
      $display("tb_source_tokenizer_stream_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ source_tokenizer_stream_unit.f @@
sv/stk_pkg.sv
sv/stk_front.sv
sv/stk_queue.sv
sv/stk_back.sv
sv/source_tokenizer_stream_unit.sv
sim/tb_source_tokenizer_stream_unit.sv
